>>> src/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CELL_W   = 16;
    localparam int OFFSET_W = 11;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CHAR_BLANK     = 8'h20;
    localparam logic [7:0] ATTR_RESET     = 8'h07;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_RETURN    = 8'd13;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_FILL,
        ST_SCROLL_PRIME,
        ST_SCROLL,
        ST_RESP
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_index(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

>>> src/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/text_console_writer_core.sv
// Text console writer: screen store, cursor and command sequencer.
// States: set_cursor and put_char go ST_EXEC, ST_RESP; read_cell adds ST_READ_WAIT;
// a scroll adds ST_SCROLL_PRIME, ST_SCROLL; clear_screen ST_FILL (one cell per cycle).
// Throughput: one item at a time; s_ready returns the cycle after the result transfer.
// Reset: synchronous, active low; then a clearing pass over all CELLS (2000) writes
// blank cells with attribute 0x07 while s_ready stays low.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [7:0]          s_char_code,
    input  logic [7:0]          s_attribute,
    input  logic [6:0]          s_column,
    input  logic [4:0]          s_row,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [6:0]          m_cursor_column,
    output logic [4:0]          m_cursor_row,
    output logic [OFFSET_W-1:0] m_cursor_offset,
    output logic [7:0]          m_cell_char,
    output logic [7:0]          m_cell_attribute
);

    localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_SPLIT = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] SCROLL_LAST  = ADDR_W'(CELLS - COLUMNS - 1);

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [7:0]         char_reg, char_next;
    logic [7:0]         attr_reg, attr_next;
    logic [COL_W-1:0]   col_in_reg, col_in_next;
    logic [ROW_W-1:0]   row_in_reg, row_in_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [7:0]         cell_char_reg, cell_char_next;
    logic [7:0]         cell_attr_reg, cell_attr_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    logic               is_nl, is_cr, is_bs;
    logic               col_at_max, col_at_zero, row_at_max, ptr_last;
    logic               put_scroll;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign is_nl       = (char_reg == CODE_NEWLINE);
    assign is_cr       = (char_reg == CODE_RETURN);
    assign is_bs       = (char_reg == CODE_BACKSPACE);
    assign col_at_max  = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign col_at_zero = (cur_col_reg == '0);
    assign row_at_max  = (cur_row_reg == ROW_W'(ROWS - 1));
    assign ptr_last    = (ptr_reg == LAST_CELL);
    assign put_scroll  = row_at_max && (is_nl || (!is_cr && !is_bs && col_at_max));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        char_reg      <= char_next;
        attr_reg      <= attr_next;
        col_in_reg    <= col_in_next;
        row_in_reg    <= row_in_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (ptr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                case (op_reg)
                    OP_PUT:   state_next = put_scroll ? ST_SCROLL_PRIME : ST_RESP;
                    OP_SET:   state_next = ST_RESP;
                    OP_CLEAR: state_next = ST_FILL;
                    OP_READ:  state_next = ST_READ_WAIT;
                    default:  state_next = ST_RESP;
                endcase
            end
            ST_READ_WAIT:    state_next = ST_RESP;
            ST_FILL: begin
                if (ptr_last) state_next = ST_RESP;
            end
            ST_SCROLL_PRIME: state_next = ST_SCROLL;
            ST_SCROLL: begin
                if (ptr_last) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default:         state_next = ST_INIT;
        endcase
    end

    // outputs and memory port control
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = {attr_reg, CHAR_BLANK};
        ram_raddr = '0;
        case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {ATTR_RESET, CHAR_BLANK};
            end
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: begin
                ram_we    = (op_reg == OP_PUT) && !is_nl && !is_cr && !(is_bs && col_at_zero);
                ram_waddr = cell_index(is_bs ? cur_col_reg - COL_W'(1) : cur_col_reg,
                                       cur_row_reg);
                ram_wdata = {attr_reg, is_bs ? CHAR_BLANK : char_reg};
                ram_raddr = cell_index(col_in_reg, row_in_reg);
            end
            ST_FILL:  ram_we = 1'b1;
            ST_SCROLL_PRIME: ram_raddr = ADDR_W'(COLUMNS);
            ST_SCROLL: begin
                ram_we    = 1'b1;
                ram_wdata = (ptr_reg < SCROLL_SPLIT) ? ram_rdata : {attr_reg, CHAR_BLANK};
                ram_raddr = (ptr_reg < SCROLL_LAST) ? ptr_reg + ADDR_W'(COLUMNS + 1) : '0;
            end
            ST_RESP:  m_valid = 1'b1;
            default:  ram_we = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        op_next        = op_reg;
        char_next      = char_reg;
        attr_next      = attr_reg;
        col_in_next    = col_in_reg;
        row_in_next    = row_in_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        ptr_next       = ptr_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        case (state_reg)
            ST_INIT, ST_FILL, ST_SCROLL: begin
                ptr_next = ptr_last ? '0 : ptr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_operation;
                    char_next      = s_char_code;
                    attr_next      = s_attribute;
                    col_in_next    = (8'(s_column) >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                                  : COL_W'(s_column);
                    row_in_next    = (7'(s_row) >= 7'(ROWS)) ? ROW_W'(ROWS - 1)
                                                            : ROW_W'(s_row);
                    cell_char_next = '0;
                    cell_attr_next = '0;
                end
            end
            ST_EXEC: begin
                ptr_next = '0;
                case (op_reg)
                    OP_PUT: begin
                        if (is_nl) begin
                            cur_col_next = '0;
                            if (!row_at_max) cur_row_next = cur_row_reg + ROW_W'(1);
                        end else if (is_cr) begin
                            cur_col_next = '0;
                        end else if (is_bs) begin
                            if (!col_at_zero) cur_col_next = cur_col_reg - COL_W'(1);
                        end else if (col_at_max) begin
                            cur_col_next = '0;
                            if (!row_at_max) cur_row_next = cur_row_reg + ROW_W'(1);
                        end else begin
                            cur_col_next = cur_col_reg + COL_W'(1);
                        end
                    end
                    OP_SET: begin
                        cur_col_next = col_in_reg;
                        cur_row_next = row_in_reg;
                    end
                    OP_CLEAR: begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                    end
                    default: cur_col_next = cur_col_reg;
                endcase
            end
            ST_READ_WAIT: begin
                cell_char_next = ram_rdata[7:0];
                cell_attr_next = ram_rdata[15:8];
            end
            default: ptr_next = ptr_reg;
        endcase
    end

    assign m_cursor_column  = 7'(cur_col_reg);
    assign m_cursor_row     = 5'(cur_row_reg);
    assign m_cursor_offset  = OFFSET_W'(cell_index(cur_col_reg, cur_row_reg));
    assign m_cell_char      = cell_char_reg;
    assign m_cell_attribute = cell_attr_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg < COL_W'(COLUMNS - 1)) || (cur_col_reg == COL_W'(COLUMNS - 1)))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_row_reg < ROW_W'(ROWS - 1)) || (cur_row_reg == ROW_W'(ROWS - 1)))
        else $error("cursor row out of range");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("sequencer did not start work after an input transfer");

    a_idle_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("sequencer did not return to idle after a result transfer");
`endif

endmodule
